// ===== design/qbvs_pkg.sv =====
// Package with shared types and constants for the vertex setup block.
package qbvs_pkg;

  localparam int SLOTS = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int MAX_BATCH_QUADS = 1024;
  localparam int QCNT_W = 11;
  localparam int ANGLE_BITS = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] OP_SUBMIT = 2'd0;
  localparam logic [1:0] OP_BEGIN = 2'd1;
  localparam logic [1:0] OP_END = 2'd2;

  // Quarter-wave polynomial constants in Q28, sized to the values they hold.
  localparam logic [29:0] PI_Q28 = 30'd843314857;
  localparam logic [28:0] C1_Q28 = 29'(64'd2 * 64'(PI_Q28) - (64'd5 << 28));
  localparam logic [25:0] C2_Q28 = 26'(64'(PI_Q28) - (64'd3 << 28));

  typedef struct packed {
    logic [1:0] operation;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] size_x;
    logic signed [31:0] size_y;
    logic [15:0] angle;
    logic [31:0] color;
    logic [15:0] tiling;
    logic [15:0] texture_handle;
  } in_item_t;

  typedef struct packed {
    logic [0:0] kind;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic [0:0] tex_u;
    logic [0:0] tex_v;
    logic [31:0] vert_color;
    logic [3:0] slot;
    logic [15:0] vert_tiling;
    logic [10:0] draw_quads;
    logic [0:0] slot_overflow;
    logic [0:0] last;
  } out_item_t;

  // Classified job handed from the front part to the back part.
  typedef struct packed {
    logic pre_draw;
    logic draw_only;
    logic [QCNT_W-1:0] draw_count;
    logic [SLOT_W-1:0] slot;
    logic overflow;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] size_x;
    logic signed [31:0] size_y;
    logic [15:0] angle;
    logic [31:0] color;
    logic [15:0] tiling;
  } job_t;

endpackage

// ===== design/qbvs_if.sv =====
// Valid/ready channel interface carrying one item per beat.
interface qbvs_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/qbvs_front.sv =====
// Front part: accepts operations, keeps batch and slot table state, emits classified jobs.
module qbvs_front import qbvs_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic [10:0] limit_i,
  input logic in_valid_i,
  output logic in_ready_o,
  input in_item_t in_data_i,
  output logic job_valid_o,
  input logic job_ready_i,
  output job_t job_o
);

  logic [15:0] table_q [SLOTS];
  logic [CNT_W-1:0] slot_cnt_q, slot_cnt_d;
  logic [QCNT_W-1:0] quad_cnt_q, quad_cnt_d;
  logic [QCNT_W-1:0] limit;
  logic full_batch;
  logic [CNT_W-1:0] eff_cnt;
  logic found;
  logic [SLOT_W-1:0] hit_slot;
  logic append;
  logic fire;

  assign in_ready_o = job_ready_i;
  assign fire = in_valid_i && job_ready_i;

  always_comb begin
    limit = limit_i;
    if (limit == '0) limit = QCNT_W'(1);
    if (limit > QCNT_W'(MAX_BATCH_QUADS)) limit = QCNT_W'(MAX_BATCH_QUADS);
  end

  assign full_batch = quad_cnt_q >= limit;
  assign eff_cnt = full_batch ? CNT_W'(1) : slot_cnt_q;

  // Parallel compare over the table; the lowest matching live slot wins.
  always_comb begin
    found = 1'b0;
    hit_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (CNT_W'(i) < eff_cnt && table_q[i] == in_data_i.texture_handle) begin
        found = 1'b1;
        hit_slot = SLOT_W'(i);
      end
    end
  end

  assign append = !found && eff_cnt < CNT_W'(SLOTS);

  always_comb begin
    job_o = '0;
    job_o.pos_x = in_data_i.pos_x;
    job_o.pos_y = in_data_i.pos_y;
    job_o.pos_z = in_data_i.pos_z;
    job_o.size_x = in_data_i.size_x;
    job_o.size_y = in_data_i.size_y;
    job_o.angle = in_data_i.angle;
    job_o.color = in_data_i.color;
    job_o.tiling = in_data_i.tiling;
    job_o.draw_count = quad_cnt_q;
    job_o.draw_only = in_data_i.operation == OP_END;
    job_o.pre_draw = full_batch;
    job_o.slot = found ? hit_slot : (append ? eff_cnt[SLOT_W-1:0] : '0);
    job_o.overflow = !found && !append;
  end

  assign job_valid_o = in_valid_i &&
      (in_data_i.operation == OP_SUBMIT || in_data_i.operation == OP_END);

  always_comb begin
    slot_cnt_d = slot_cnt_q;
    quad_cnt_d = quad_cnt_q;
    if (fire) begin
      unique case (in_data_i.operation)
        OP_BEGIN: begin
          slot_cnt_d = CNT_W'(1);
          quad_cnt_d = '0;
        end
        OP_SUBMIT: begin
          slot_cnt_d = append ? eff_cnt + CNT_W'(1) : eff_cnt;
          quad_cnt_d = (full_batch ? '0 : quad_cnt_q) + QCNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_cnt_q <= CNT_W'(1);
      quad_cnt_q <= '0;
      for (int i = 0; i < SLOTS; i++) table_q[i] <= '0;
    end else begin
      slot_cnt_q <= slot_cnt_d;
      quad_cnt_q <= quad_cnt_d;
      if (fire && in_data_i.operation == OP_SUBMIT && append) begin
        table_q[eff_cnt[SLOT_W-1:0]] <= in_data_i.texture_handle;
      end
    end
  end

endmodule

// ===== design/qbvs_queue.sv =====
// Short job queue between the front and the back part.
module qbvs_queue import qbvs_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic wr_valid_i,
  output logic wr_ready_o,
  input job_t wr_data_i,
  output logic rd_valid_o,
  input logic rd_ready_i,
  output job_t rd_data_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0] cnt_q;
  logic push, pop;

  assign wr_ready_o = cnt_q < (PTR_W+1)'(QUEUE_DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o = mem_q[rd_ptr_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      cnt_q <= cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

// ===== design/qbvs_back.sv =====
// Back part: emits draw items and the four transformed corner vertices of each quad.
module qbvs_back import qbvs_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic job_valid_i,
  output logic job_ready_o,
  input job_t job_i,
  qbvs_if.source out_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TRIG = 3'd1;
  localparam logic [2:0] ST_MUL = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;

  localparam logic [1:0] TS_SQUARE = 2'd0;
  localparam logic [1:0] TS_POLY_T = 2'd1;
  localparam logic [1:0] TS_POLY_U = 2'd2;
  localparam logic [1:0] TS_SINE = 2'd3;

  logic [2:0] state_q, state_d;
  logic [1:0] trig_q, trig_d;
  job_t job_q;
  logic pre_q, pre_d;
  logic [1:0] corner_q, corner_d;
  logic signed [16:0] sin_q, cos_q;
  logic signed [48:0] xc_q, xs_q, yc_q, ys_q;
  logic [28:0] x2s_q, x2c_q, ts_q, tc_q;
  logic [29:0] us_q, uc_q;
  logic [15:0] a;
  logic [1:0] quad;
  logic [13:0] ph;
  logic [14:0] ps, pc;
  logic [29:0] sq_s, sq_c;
  logic [54:0] m1_s, m1_c;
  logic [57:0] m2_s, m2_c;
  logic [45:0] m3_s, m3_c;
  logic [15:0] sp, sc;
  logic signed [16:0] s_d, c_d;
  logic signed [49:0] rx_full, ry_full;
  logic signed [49:0] sx_c, sx_s, sy_c, sy_s;
  logic cu, cv;
  logic out_free;
  out_item_t res_q, res_d;
  logic res_valid_q, res_valid_d;
  logic load;

  assign out_free = !res_valid_q || out_o.ready;
  assign out_o.valid = res_valid_q;
  assign out_o.data = res_q;
  assign job_ready_o = state_q == ST_IDLE && out_free;

  assign a = (job_q.angle >> (16 - ANGLE_BITS)) << (16 - ANGLE_BITS);
  assign quad = a[15:14];
  assign ph = a[13:0];

  // The sine and cosine phases are evaluated side by side, one polynomial step per cycle.
  assign ps = {1'b0, ph};
  assign pc = 15'd16384 - {1'b0, ph};
  assign sq_s = ps * ps;
  assign sq_c = pc * pc;
  assign m1_s = x2s_q * C2_Q28;
  assign m1_c = x2c_q * C2_Q28;
  assign m2_s = x2s_q * ts_q;
  assign m2_c = x2c_q * tc_q;
  assign m3_s = ps * us_q + (46'd1 << 27);
  assign m3_c = pc * uc_q + (46'd1 << 27);
  assign sp = m3_s[43:28];
  assign sc = m3_c[43:28];

  always_comb begin
    unique case (quad)
      2'd0: begin s_d = $signed({1'b0, sp}); c_d = $signed({1'b0, sc}); end
      2'd1: begin s_d = $signed({1'b0, sc}); c_d = -$signed({1'b0, sp}); end
      2'd2: begin s_d = -$signed({1'b0, sp}); c_d = -$signed({1'b0, sc}); end
      default: begin s_d = -$signed({1'b0, sc}); c_d = $signed({1'b0, sp}); end
    endcase
  end

  assign cu = corner_q == 2'd1 || corner_q == 2'd2;
  assign cv = corner_q[1];
  assign sx_c = cu ? 50'(xc_q) : '0;
  assign sx_s = cu ? 50'(xs_q) : '0;
  assign sy_c = cv ? 50'(yc_q) : '0;
  assign sy_s = cv ? 50'(ys_q) : '0;
  assign rx_full = (sx_c - sy_s + 50'sd16384) >>> 15;
  assign ry_full = (sx_s + sy_c + 50'sd16384) >>> 15;
  assign load = job_valid_i && job_ready_o;

  always_comb begin
    state_d = state_q;
    trig_d = trig_q;
    pre_d = pre_q;
    corner_d = corner_q;
    unique case (state_q)
      ST_IDLE: if (load) begin
        pre_d = job_i.pre_draw;
        corner_d = '0;
        trig_d = TS_SQUARE;
        state_d = job_i.draw_only ? ST_IDLE : ST_TRIG;
      end
      ST_TRIG: begin
        trig_d = trig_q + 2'd1;
        if (trig_q == TS_SINE) state_d = ST_MUL;
      end
      ST_MUL: state_d = ST_EMIT;
      ST_EMIT: if (out_free) begin
        if (pre_q) pre_d = 1'b0;
        else begin
          corner_d = corner_q + 2'd1;
          if (corner_q == 2'd3) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_d = res_q;
    res_valid_d = res_valid_q;
    if (out_free) begin
      res_valid_d = 1'b0;
      if (state_q == ST_IDLE && load && job_i.draw_only) begin
        res_d = '0;
        res_d.kind = 1'b1;
        res_d.draw_quads = job_i.draw_count;
        res_d.last = 1'b1;
        res_valid_d = 1'b1;
      end else if (state_q == ST_EMIT) begin
        res_d = '0;
        res_valid_d = 1'b1;
        if (pre_q) begin
          res_d.kind = 1'b1;
          res_d.draw_quads = job_q.draw_count;
        end else begin
          res_d.vert_x = job_q.pos_x + 32'(rx_full);
          res_d.vert_y = job_q.pos_y + 32'(ry_full);
          res_d.vert_z = job_q.pos_z;
          res_d.tex_u = cu;
          res_d.tex_v = cv;
          res_d.vert_color = job_q.color;
          res_d.slot = 4'(job_q.slot);
          res_d.vert_tiling = job_q.tiling;
          res_d.slot_overflow = job_q.overflow;
          res_d.last = corner_q == 2'd3;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      trig_q <= TS_SQUARE;
      pre_q <= 1'b0;
      corner_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      trig_q <= trig_d;
      pre_q <= pre_d;
      corner_q <= corner_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) job_q <= job_i;
    if (state_q == ST_TRIG) begin
      case (trig_q)
        TS_SQUARE: begin
          x2s_q <= sq_s[28:0];
          x2c_q <= sq_c[28:0];
        end
        TS_POLY_T: begin
          ts_q <= C1_Q28 - 29'(m1_s[54:28]);
          tc_q <= C1_Q28 - 29'(m1_c[54:28]);
        end
        TS_POLY_U: begin
          us_q <= PI_Q28 - m2_s[57:28];
          uc_q <= PI_Q28 - m2_c[57:28];
        end
        default: begin
          sin_q <= s_d;
          cos_q <= c_d;
        end
      endcase
    end
    if (state_q == ST_MUL) begin
      xc_q <= job_q.size_x * cos_q;
      xs_q <= job_q.size_x * sin_q;
      yc_q <= job_q.size_y * cos_q;
      ys_q <= job_q.size_y * sin_q;
    end
    res_q <= res_d;
  end

endmodule

// ===== design/quad_batch_vertex_setup.sv =====
// Sprite batch vertex setup: one submitted quad yields four vertex beats, one per cycle
// while the receiver is ready. The back part takes a quad through load, four sine steps,
// multiply and its four beats, with one draw beat first for an automatic draw, before it
// takes the next job; an end scene job yields one draw beat from the idle state.
// Reset clears the quad count and slot table and sets the slot count to one; the limit
// register resets to 1000.
module quad_batch_vertex_setup import qbvs_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic cfg_we_i,
  input logic [10:0] cfg_wdata_i,
  qbvs_if.sink in_i,
  qbvs_if.source out_o
);

  logic [10:0] limit_q;
  logic fj_valid, fj_ready, bj_valid, bj_ready;
  job_t fj, bj;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= 11'd1000;
    else if (cfg_we_i) limit_q <= cfg_wdata_i;
  end

  qbvs_front u_front (
    .clk_i, .rst_ni, .limit_i(limit_q),
    .in_valid_i(in_i.valid), .in_ready_o(in_i.ready), .in_data_i(in_i.data),
    .job_valid_o(fj_valid), .job_ready_i(fj_ready), .job_o(fj)
  );

  qbvs_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fj_valid), .wr_ready_o(fj_ready), .wr_data_i(fj),
    .rd_valid_o(bj_valid), .rd_ready_i(bj_ready), .rd_data_o(bj)
  );

  qbvs_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(bj_valid), .job_ready_o(bj_ready), .job_i(bj),
    .out_o(out_o)
  );

endmodule

// ===== tb/sv/quad_batch_vertex_setup_test.sv =====
// Self-checking testbench for the quad batch vertex setup block with a built-in vertex predictor.
module quad_batch_vertex_setup_test;
  timeunit 1ns;
  timeprecision 1ps;
  import qbvs_pkg::*;

  localparam longint unsigned PI_FX = 64'd843314857;
  localparam longint unsigned C1_FX = 64'd2 * PI_FX - (64'd5 << 28);
  localparam longint unsigned C2_FX = PI_FX - (64'd3 << 28);
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    in_item_t item;
    bit typed;
    logic [10:0] typed_quads;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;

  qbvs_if #(.T(in_item_t)) in_ch ();
  qbvs_if #(.T(out_item_t)) out_ch ();

  quad_batch_vertex_setup dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i(in_ch),
    .out_o(out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state.
  logic [15:0] slot_map [SLOTS];
  int unsigned slots_used;
  int unsigned quads_held;
  logic [10:0] quad_limit;

  out_item_t vertex_q [$];
  int errors = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;
  int stall_cycles = 0;
  logic [15:0] handle_pool [20];

  function automatic longint quarter_wave(int unsigned p);
    longint unsigned x2, t, u, pp;
    pp = p;
    x2 = pp * pp;
    t = C1_FX - ((x2 * C2_FX) >> 28);
    u = PI_FX - ((x2 * t) >> 28);
    return longint'((pp * u + (64'd1 << 27)) >> 28);
  endfunction

  function automatic out_item_t draw_beat(logic [10:0] quads, bit is_last);
    out_item_t r;
    r = '0;
    r.kind = 1'b1;
    r.draw_quads = quads;
    r.last = is_last;
    return r;
  endfunction

  // Updates the predictor state and returns the beats one input causes.
  function automatic void predict_vertices(in_item_t it, output out_item_t res [$]);
    int unsigned lim, slot, q, p, a;
    bit found, ovf;
    longint sp, sc, s, c, px, py, sx, sy, rx, ry;
    out_item_t r;
    bit cu [4];
    bit cv [4];
    cu = '{0, 1, 1, 0};
    cv = '{0, 0, 1, 1};
    res = {};
    case (it.operation)
      OP_BEGIN: begin
        quads_held = 0;
        slots_used = 1;
        return;
      end
      OP_END: begin
        res.push_back(draw_beat(11'(quads_held), 1'b1));
        return;
      end
      OP_SUBMIT: ;
      default: return;
    endcase
    lim = quad_limit;
    if (lim < 1) lim = 1;
    if (lim > MAX_BATCH_QUADS) lim = MAX_BATCH_QUADS;
    if (quads_held >= lim) begin
      res.push_back(draw_beat(11'(quads_held), 1'b0));
      quads_held = 0;
      slots_used = 1;
    end
    found = 1'b0;
    ovf = 1'b0;
    slot = 0;
    for (int i = 0; i < slots_used && i < SLOTS; i++) begin
      if (!found && slot_map[i] == it.texture_handle) begin
        slot = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      if (slots_used < SLOTS) begin
        slot = slots_used;
        slot_map[slots_used] = it.texture_handle;
        slots_used++;
      end else begin
        ovf = 1'b1;
      end
    end
    a = it.angle;
    a = (a >> (16 - ANGLE_BITS)) << (16 - ANGLE_BITS);
    q = a >> 14;
    p = a & 32'h3FFF;
    sp = quarter_wave(p);
    sc = quarter_wave(16384 - p);
    case (q)
      0: begin s = sp; c = sc; end
      1: begin s = sc; c = -sp; end
      2: begin s = -sp; c = -sc; end
      default: begin s = -sc; c = sp; end
    endcase
    px = it.pos_x;
    py = it.pos_y;
    for (int k = 0; k < 4; k++) begin
      sx = cu[k] ? longint'(it.size_x) : 0;
      sy = cv[k] ? longint'(it.size_y) : 0;
      rx = (sx * c - sy * s + 16384) >>> 15;
      ry = (sx * s + sy * c + 16384) >>> 15;
      r = '0;
      r.vert_x = 32'(px + rx);
      r.vert_y = 32'(py + ry);
      r.vert_z = it.pos_z;
      r.tex_u = cu[k];
      r.tex_v = cv[k];
      r.vert_color = it.color;
      r.slot = 4'(slot);
      r.vert_tiling = it.tiling;
      r.slot_overflow = ovf;
      r.last = (k == 3);
      res.push_back(r);
    end
    quads_held++;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  task automatic check_beat(out_item_t got);
    out_item_t want;
    if (vertex_q.size() == 0) begin
      report_mismatch("beat with nothing expected", got.kind, 0);
      return;
    end
    want = vertex_q.pop_front();
    if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
    if (got.vert_x !== want.vert_x) report_mismatch("vert_x", got.vert_x, want.vert_x);
    if (got.vert_y !== want.vert_y) report_mismatch("vert_y", got.vert_y, want.vert_y);
    if (got.vert_z !== want.vert_z) report_mismatch("vert_z", got.vert_z, want.vert_z);
    if (got.tex_u !== want.tex_u) report_mismatch("tex_u", got.tex_u, want.tex_u);
    if (got.tex_v !== want.tex_v) report_mismatch("tex_v", got.tex_v, want.tex_v);
    if (got.vert_color !== want.vert_color)
      report_mismatch("vert_color", got.vert_color, want.vert_color);
    if (got.slot !== want.slot) report_mismatch("slot", got.slot, want.slot);
    if (got.vert_tiling !== want.vert_tiling)
      report_mismatch("vert_tiling", got.vert_tiling, want.vert_tiling);
    if (got.draw_quads !== want.draw_quads)
      report_mismatch("draw_quads", got.draw_quads, want.draw_quads);
    if (got.slot_overflow !== want.slot_overflow)
      report_mismatch("slot_overflow", got.slot_overflow, want.slot_overflow);
    if (got.last !== want.last) report_mismatch("last", got.last, want.last);
  endtask

  // Receiver: checks each beat and stalls at random, with one long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_beat(out_ch.data);
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ch.ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_cnt <= 300;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(0, 99) >= 18);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && !((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))) begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end else begin
      stall_cycles <= 0;
    end
  end

  task automatic send_item(in_item_t it);
    out_item_t res [$];
    in_ch.data <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    predict_vertices(it, res);
    foreach (res[i]) vertex_q.push_back(res[i]);
    if (!quiet && $urandom_range(0, 99) < 18) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic send_typed(stim_row_t row);
    out_item_t res [$];
    in_ch.data <= row.item;
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    predict_vertices(row.item, res);
    if (row.typed) vertex_q.push_back(draw_beat(row.typed_quads, 1'b1));
    else foreach (res[i]) vertex_q.push_back(res[i]);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [10:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    quad_limit = v;
  endtask

  function automatic in_item_t make_item(logic [1:0] op, logic [31:0] pos, logic [31:0] size,
                                         logic [15:0] ang, logic [31:0] col, logic [15:0] hnd);
    in_item_t it;
    it.operation = op;
    it.pos_x = pos;
    it.pos_y = ~pos;
    it.pos_z = pos ^ 32'h5A5A_A5A5;
    it.size_x = size;
    it.size_y = ~size;
    it.angle = ang;
    it.color = col;
    it.tiling = col[15:0];
    it.texture_handle = hnd;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned r;
    r = $urandom_range(0, 99);
    it.operation = (r < 70) ? OP_SUBMIT : (r < 78) ? OP_BEGIN : (r < 93) ? OP_END : OP_UNUSED;
    it.pos_x = $urandom;
    it.pos_y = $urandom;
    it.pos_z = $urandom;
    it.size_x = $urandom;
    it.size_y = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      it.size_x = $signed(it.size_x) >>> 12;
      it.size_y = $signed(it.size_y) >>> 12;
    end
    it.angle = 16'($urandom);
    if ($urandom_range(0, 4) == 0) it.angle = 16'($urandom_range(0, 3) << 14);
    it.color = $urandom;
    it.tiling = 16'($urandom);
    it.texture_handle = handle_pool[$urandom_range(0, 19)];
    return it;
  endfunction

  stim_row_t rows [$];
  logic [10:0] limits [6] = '{11'd1, 11'd0, 11'd2047, 11'd1024, 11'd3, 11'd7};

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    slot_map = '{default: 16'd0};
    slots_used = 1;
    quads_held = 0;
    quad_limit = 11'd1000;
    handle_pool[0] = 16'd0;
    handle_pool[19] = 16'hFFFF;
    for (int i = 1; i < 19; i++) handle_pool[i] = 16'($urandom_range(1, 16'hFFFE));

    // Directed rows; only the draw counts of end scene are typed in.
    rows.push_back('{make_item(OP_END, '0, '0, '0, '0, '0), 1'b1, 11'd0});
    rows.push_back('{make_item(OP_SUBMIT, '0, '0, '0, '0, '0), 1'b0, '0});
    rows.push_back('{make_item(OP_SUBMIT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd16384,
                               32'hFFFF_FFFF, 16'hFFFF), 1'b0, '0});
    rows.push_back('{make_item(OP_SUBMIT, 32'h8000_0000, 32'h8000_0000, 16'd32768,
                               32'h0000_0000, 16'h0001), 1'b0, '0});
    rows.push_back('{make_item(OP_SUBMIT, 32'h0001_0000, 32'h0010_0000, 16'd49152,
                               32'h1234_5678, 16'hFFFF), 1'b0, '0});
    rows.push_back('{make_item(OP_SUBMIT, 32'hFFFF_0000, 32'h8000_0000, 16'hFFFF,
                               32'hDEAD_BEEF, 16'h0000), 1'b0, '0});
    rows.push_back('{make_item(OP_SUBMIT, 32'h7FFF_FFFF, 32'h0001_0000, 16'd8192,
                               32'hAAAA_5555, 16'h8000), 1'b0, '0});
    rows.push_back('{make_item(OP_END, '0, '0, '0, '0, '0), 1'b1, 11'd6});
    rows.push_back('{make_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                               32'hFFFF_FFFF, 16'hFFFF), 1'b0, '0});
    rows.push_back('{make_item(OP_END, '0, '0, '0, '0, '0), 1'b1, 11'd6});
    rows.push_back('{make_item(OP_BEGIN, '0, '0, '0, '0, '0), 1'b0, '0});
    rows.push_back('{make_item(OP_END, '0, '0, '0, '0, '0), 1'b1, 11'd0});
    rows.push_back('{make_item(OP_SUBMIT, 32'h0002_8000, 32'hFFFE_0000, 16'd1,
                               32'h0F0F_0F0F, 16'h0002), 1'b0, '0});
    rows.push_back('{make_item(OP_END, '0, '0, '0, '0, '0), 1'b1, 11'd1});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_typed(rows[i]);
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      write_limit(ph < 6 ? limits[ph] : 11'($urandom_range(1, 12)));
      quiet = (ph == 2);
      if (ph == 4) hold_req = 1'b1;
      for (int n = 0; n < 21; n++) send_item(random_item());
      quiet = 1'b0;
      wait_idle();
    end

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
